>>> hdl/cfla_pkg.sv
// Shared types and constants for the coalescing free-list allocator.
// No dependencies; used by every other file in this folder.
package cfla_pkg;

   localparam int DEFAULT_MAX_ENTRIES = 256;
   localparam int ADDR_W = 32;
   localparam int COUNT_OUT_W = 9;
   localparam int GROUP = 16;
   localparam int GROUP_W = 4;

   localparam logic [ADDR_W-1:0] PAGE_ADD = 32'h0000_0FFF;
   localparam logic [ADDR_W-1:0] PAGE_MASK = 32'hFFFF_F000;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE = 1'b1;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT = 2'd1;
   localparam logic [1:0] STATUS_LOST = 2'd2;

   // one free region
   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] len;
   } entry_type;

   // update command broadcast along the cell row
   typedef struct packed {
      logic go;
      logic wr_en;
      logic shift_up;
      logic shift_dn;
   } cell_ctl_type;

endpackage

>>> hdl/cfla_if.sv
// Handshake channels for request and response items.
// Depends on cfla_pkg for field widths.
interface cfla_req_if;
   import cfla_pkg::*;
   logic valid;
   logic ready;
   logic operation;
   logic [ADDR_W-1:0] region_addr;
   logic [ADDR_W-1:0] region_size;
   modport source (output valid, operation, region_addr, region_size, input ready);
   modport sink (input valid, operation, region_addr, region_size, output ready);
endinterface

interface cfla_rsp_if;
   import cfla_pkg::*;
   logic valid;
   logic ready;
   logic [ADDR_W-1:0] alloc_address;
   logic [1:0] status;
   logic [ADDR_W-1:0] free_total;
   logic [COUNT_OUT_W-1:0] entry_count;
   logic [COUNT_OUT_W-1:0] peak_entry_count;
   logic [ADDR_W-1:0] lost_count;
   logic [ADDR_W-1:0] lost_bytes;
   modport source (output valid, alloc_address, status, free_total, entry_count,
                   peak_entry_count, lost_count, lost_bytes, input ready);
   modport sink (input valid, alloc_address, status, free_total, entry_count,
                 peak_entry_count, lost_count, lost_bytes, output ready);
endinterface

>>> hdl/cfla_cell.sv
// One table slot: holds a region, tests it against the search key and
// shifts to or from its neighbours. Depends on cfla_pkg.
module cfla_cell #(
   parameter int CNT_W = 9,
   parameter int ID = 0
) (
   input  logic                       clock,
   input  logic                       valid,
   input  logic                       op,
   input  logic [cfla_pkg::ADDR_W-1:0] key_addr,
   input  logic [cfla_pkg::ADDR_W-1:0] key_size,
   output logic                       flag,
   input  cfla_pkg::entry_type        prev_entry,
   input  cfla_pkg::entry_type        next_entry,
   output cfla_pkg::entry_type        entry,
   input  cfla_pkg::cell_ctl_type     ctl,
   input  logic [CNT_W-1:0]           wr_pos,
   input  logic [CNT_W-1:0]           shift_pos,
   input  cfla_pkg::entry_type        wr_entry,
   input  logic [CNT_W-1:0]           rd_pos,
   output cfla_pkg::entry_type        rd_cur,
   output cfla_pkg::entry_type        rd_prev
);
   import cfla_pkg::*;

   localparam logic [CNT_W-1:0] MY_POS = CNT_W'(ID);
   localparam logic [CNT_W-1:0] NEXT_POS = CNT_W'(ID + 1);

   entry_type entry_ff;
   logic flag_ff;

   // key test: free looks for the first start above the address,
   // allocate for the first region long enough
   always_ff @(posedge clock) begin
      flag_ff <= valid & ((op == OP_FREE) ? (entry_ff.start > key_addr)
                                          : (entry_ff.len >= key_size));
   end

   // write wins, else shift one place up (insert) or down (remove)
   always_ff @(posedge clock) begin
      if (ctl.go) begin
         if (ctl.wr_en && wr_pos == MY_POS) begin
            entry_ff <= wr_entry;
         end else if (ctl.shift_up && MY_POS > shift_pos) begin
            entry_ff <= prev_entry;
         end else if (ctl.shift_dn && MY_POS >= shift_pos) begin
            entry_ff <= next_entry;
         end
      end
   end

   assign flag = flag_ff;
   assign entry = entry_ff;
   assign rd_cur = (rd_pos == MY_POS) ? entry_ff : '0;
   assign rd_prev = (rd_pos == NEXT_POS) ? entry_ff : '0;

endmodule

>>> hdl/cfla_find.sv
// Two-stage registered first-set search over the cell flags.
// Depends on cfla_pkg for the group size.
module cfla_find #(
   parameter int N = 256,
   parameter int IDX_W = 8
) (
   input  logic             clock,
   input  logic [N-1:0]     flags,
   output logic             found,
   output logic [IDX_W-1:0] idx
);
   import cfla_pkg::*;

   localparam int NG = (N + GROUP - 1) / GROUP;

   logic [NG*GROUP-1:0] flags_pad;
   logic [NG-1:0] grp_any_ff;
   logic [GROUP_W-1:0] grp_loc_ff [NG];
   logic [GROUP_W-1:0] grp_loc_in [NG];
   logic found_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;

   assign flags_pad = (NG*GROUP)'(flags);

   // first flag inside each group, lowest position wins
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_loc_in[g] = '0;
         for (int b = GROUP - 1; b >= 0; b--) begin
            if (flags_pad[g*GROUP + b]) grp_loc_in[g] = GROUP_W'(b);
         end
      end
   end

   // stage one: per group, any flag and first flag
   always_ff @(posedge clock) begin
      for (int g = 0; g < NG; g++) begin
         grp_any_ff[g] <= |flags_pad[g*GROUP +: GROUP];
         grp_loc_ff[g] <= grp_loc_in[g];
      end
   end

   // first group that has a flag, lowest group wins
   always_comb begin
      idx_in = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) idx_in = IDX_W'(g * GROUP + int'(grp_loc_ff[g]));
      end
   end

   // stage two: register the winner
   always_ff @(posedge clock) begin
      found_ff <= |grp_any_ff;
      idx_ff <= idx_in;
   end

   assign found = found_ff;
   assign idx = idx_ff;

endmodule

>>> hdl/coalescing_free_list_allocator.sv
// First-fit free-region allocator with coalescing, built as a row of cells.
// Each request passes through key test, two search stages, index capture,
// neighbour read, decision, cell update and response load in turn.
// A new request is accepted only once the last one has been answered;
// a response held by the sink stalls the next item in the output stage.
// Reset clears counters, totals and the page mode; cell contents stay
// undefined until written, only slots below the entry count are used.
module coalescing_free_list_allocator #(
   parameter int MAX_ENTRIES = cfla_pkg::DEFAULT_MAX_ENTRIES
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   csr_wr_en,
   input  logic   csr_wr_data,
   cfla_req_if.sink   req,
   cfla_rsp_if.source rsp
);
   import cfla_pkg::*;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_ENTRIES);

   typedef enum logic [3:0] {
      S_IDLE, S_FLAG, S_GRP, S_SRCH, S_IDX, S_READ, S_EXEC, S_APPLY, S_OUT
   } state_type;

   state_type state_ff;
   logic page_ff;
   logic op_ff;
   logic [ADDR_W-1:0] addr_ff, size_ff, end_ff;
   logic [CNT_W-1:0] count_ff, peak_ff, pos_ff;
   logic found_ff;
   logic [ADDR_W-1:0] sum_ff, lost_cnt_ff, lost_bytes_ff;
   entry_type cur_ff, prev_ff;
   cell_ctl_type ctl_ff, ctl;
   logic [CNT_W-1:0] wr_pos_ff, shift_pos_ff;
   entry_type wr_entry_ff;
   logic [ADDR_W-1:0] res_addr_ff;
   logic [1:0] res_status_ff;
   logic rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_sum_ff, rsp_lcnt_ff, rsp_lbytes_ff;
   logic [1:0] rsp_status_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_peak_ff;

   logic [ADDR_W-1:0] size_in;
   entry_type entries [MAX_ENTRIES];
   entry_type rd_cur [MAX_ENTRIES];
   entry_type rd_prev [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] flags;
   logic find_found;
   logic [IDX_W-1:0] find_idx;
   entry_type cur_in, prev_in;
   logic [ADDR_W-1:0] prev_end, rem_len;
   logic prev_ok, next_ok;

   assign size_in = page_ff ? ((req.region_size + PAGE_ADD) & PAGE_MASK) : req.region_size;
   assign ctl = '{go: (state_ff == S_APPLY), wr_en: ctl_ff.wr_en,
                  shift_up: ctl_ff.shift_up, shift_dn: ctl_ff.shift_dn};

   // row of table cells
   for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
      entry_type prev_e, next_e;
      if (k == 0) begin : g_first
         assign prev_e = '0;
      end else begin : g_mid
         assign prev_e = entries[k-1];
      end
      if (k == MAX_ENTRIES - 1) begin : g_last
         assign next_e = '0;
      end else begin : g_inner
         assign next_e = entries[k+1];
      end
      cfla_cell #(.CNT_W(CNT_W), .ID(k)) u_cell (
         .clock(clock), .valid(CNT_W'(k) < count_ff), .op(op_ff),
         .key_addr(addr_ff), .key_size(size_ff), .flag(flags[k]),
         .prev_entry(prev_e), .next_entry(next_e), .entry(entries[k]),
         .ctl(ctl), .wr_pos(wr_pos_ff), .shift_pos(shift_pos_ff),
         .wr_entry(wr_entry_ff), .rd_pos(pos_ff),
         .rd_cur(rd_cur[k]), .rd_prev(rd_prev[k])
      );
   end

   cfla_find #(.N(MAX_ENTRIES), .IDX_W(IDX_W)) u_find (
      .clock(clock), .flags(flags), .found(find_found), .idx(find_idx)
   );

   // gather the selected slot and the one before it
   always_comb begin
      cur_in = '0;
      prev_in = '0;
      for (int k = 0; k < MAX_ENTRIES; k++) begin
         cur_in = cur_in | rd_cur[k];
         prev_in = prev_in | rd_prev[k];
      end
   end

   // merge tests and carve remainder
   assign prev_end = prev_ff.start + prev_ff.len;
   assign prev_ok = (pos_ff != '0) && (prev_end == addr_ff);
   assign next_ok = found_ff && (end_ff == cur_ff.start);
   assign rem_len = cur_ff.len - size_ff;

   // sequencer, counters and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         page_ff <= 1'b0;
         count_ff <= '0;
         peak_ff <= '0;
         sum_ff <= '0;
         lost_cnt_ff <= '0;
         lost_bytes_ff <= '0;
         rsp_valid_ff <= 1'b0;
         ctl_ff <= '0;
      end else begin
         if (csr_wr_en) page_ff <= csr_wr_data;
         if (rsp_valid_ff && rsp.ready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  op_ff <= req.operation;
                  addr_ff <= req.region_addr;
                  size_ff <= size_in;
                  end_ff <= req.region_addr + size_in;
                  state_ff <= S_FLAG;
               end
            end
            S_FLAG: state_ff <= S_GRP;
            S_GRP: state_ff <= S_SRCH;
            S_SRCH: state_ff <= S_IDX;
            S_IDX: begin
               found_ff <= find_found;
               pos_ff <= find_found ? CNT_W'(find_idx) : count_ff;
               state_ff <= S_READ;
            end
            S_READ: begin
               cur_ff <= cur_in;
               prev_ff <= prev_in;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               res_addr_ff <= (op_ff == OP_ALLOC && found_ff) ? cur_ff.start : '0;
               if (op_ff == OP_ALLOC) begin
                  if (found_ff) begin
                     res_status_ff <= STATUS_OK;
                     sum_ff <= sum_ff - size_ff;
                     if (rem_len == '0) begin
                        ctl_ff <= '{go: 1'b0, wr_en: 1'b0, shift_up: 1'b0,
                                    shift_dn: 1'b1};
                        shift_pos_ff <= pos_ff;
                        count_ff <= count_ff - 1'b1;
                     end else begin
                        ctl_ff <= '{go: 1'b0, wr_en: 1'b1, shift_up: 1'b0,
                                    shift_dn: 1'b0};
                        wr_pos_ff <= pos_ff;
                        wr_entry_ff <= '{start: cur_ff.start + size_ff, len: rem_len};
                     end
                  end else begin
                     res_status_ff <= STATUS_NO_FIT;
                     ctl_ff <= '0;
                  end
               end else if (prev_ok) begin
                  res_status_ff <= STATUS_OK;
                  ctl_ff <= '{go: 1'b0, wr_en: 1'b1, shift_up: 1'b0,
                              shift_dn: next_ok};
                  wr_pos_ff <= pos_ff - 1'b1;
                  wr_entry_ff <= '{start: prev_ff.start,
                                   len: prev_ff.len + size_ff
                                        + (next_ok ? cur_ff.len : '0)};
                  if (next_ok) begin
                     shift_pos_ff <= pos_ff;
                     count_ff <= count_ff - 1'b1;
                  end
                  sum_ff <= sum_ff + size_ff;
               end else if (next_ok) begin
                  res_status_ff <= STATUS_OK;
                  ctl_ff <= '{go: 1'b0, wr_en: 1'b1, shift_up: 1'b0,
                              shift_dn: 1'b0};
                  wr_pos_ff <= pos_ff;
                  wr_entry_ff <= '{start: addr_ff, len: cur_ff.len + size_ff};
                  sum_ff <= sum_ff + size_ff;
               end else if (count_ff < FULL) begin
                  res_status_ff <= STATUS_OK;
                  ctl_ff <= '{go: 1'b0, wr_en: 1'b1, shift_up: 1'b1,
                              shift_dn: 1'b0};
                  wr_pos_ff <= pos_ff;
                  shift_pos_ff <= pos_ff;
                  wr_entry_ff <= '{start: addr_ff, len: size_ff};
                  count_ff <= count_ff + 1'b1;
                  if (peak_ff < count_ff + 1'b1) peak_ff <= count_ff + 1'b1;
                  sum_ff <= sum_ff + size_ff;
               end else begin
                  res_status_ff <= STATUS_LOST;
                  ctl_ff <= '0;
                  lost_cnt_ff <= lost_cnt_ff + 1'b1;
                  lost_bytes_ff <= lost_bytes_ff + size_ff;
               end
               state_ff <= S_APPLY;
            end
            S_APPLY: state_ff <= S_OUT;
            S_OUT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_addr_ff <= res_addr_ff;
                  rsp_status_ff <= res_status_ff;
                  rsp_sum_ff <= sum_ff;
                  rsp_count_ff <= COUNT_OUT_W'(count_ff);
                  rsp_peak_ff <= COUNT_OUT_W'(peak_ff);
                  rsp_lcnt_ff <= lost_cnt_ff;
                  rsp_lbytes_ff <= lost_bytes_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.alloc_address = rsp_addr_ff;
   assign rsp.status = rsp_status_ff;
   assign rsp.free_total = rsp_sum_ff;
   assign rsp.entry_count = rsp_count_ff;
   assign rsp.peak_entry_count = rsp_peak_ff;
   assign rsp.lost_count = rsp_lcnt_ff;
   assign rsp.lost_bytes = rsp_lbytes_ff;

endmodule
